// ===== rtl/set_assoc_lru_cache_sim_core_assert.svh =====
// Assertion macros for the cache model RTL, used by the back end.
`ifndef SET_ASSOC_LRU_CACHE_SIM_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SALC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("salc assertion failed");
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("salc assertion failed");
`else
`define SALC_ASSERT_IMP(lbl, ante, cons)
`define SALC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/salc_pkg.sv =====
// Types, constants and helpers of the set-associative LRU cache model.
package salc_pkg;

	localparam int MAX_SET_BITS = 8;
	localparam int MAX_WAYS = 8;
	localparam int ADDR_WIDTH = 32;

	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam int NW_W = $clog2(MAX_WAYS + 1);
	localparam int TAG_W = ADDR_WIDTH;
	localparam int SHAMT_W = 6;
	localparam int CNT_W = 32;

	localparam int SETB_W = 4;
	localparam int BLKB_W = 5;
	localparam int WAYS_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;

	localparam int KIND_W = 2;
	localparam int HITS_W = 2;

	localparam int LINK_DEPTH = 2;
	localparam int LPTR_W = $clog2(LINK_DEPTH);
	localparam int LCNT_W = $clog2(LINK_DEPTH + 1);
	localparam int OUT_DEPTH = 2;
	localparam int OPTR_W = $clog2(OUT_DEPTH);
	localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS = 2'd2;

	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

	typedef struct packed {
		logic [SETB_W-1:0] set_bits;
		logic [BLKB_W-1:0] block_bits;
		logic [WAYS_W-1:0] ways;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SET_W-1:0]  set_idx;
		logic [TAG_W-1:0]  tag;
	} req_t;

	typedef struct packed {
		logic [HITS_W-1:0] hits_now;
		logic              missed;
		logic              evicted;
		logic [CNT_W-1:0]  total_hits;
		logic [CNT_W-1:0]  total_misses;
		logic [CNT_W-1:0]  total_evictions;
	} rsp_t;

	typedef struct packed {
		logic [MAX_WAYS-1:0]             valid;
		logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
		logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
	} row_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
		input logic [HITS_W-1:0] inc);
		logic [CNT_W:0] sum;
		sum = {1'b0, v} + (CNT_W+1)'(inc);
		return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
	endfunction

endpackage

// ===== rtl/salc_link_q.sv =====
// Short request queue between the classifying front and the cache back end.
module salc_link_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  salc_pkg::req_t    wr_req,
	input  logic              pop,
	output salc_pkg::req_t    rd_req,
	output salc_pkg::q_stat_t stat
);

	salc_pkg::req_t buf_q [salc_pkg::LINK_DEPTH];
	logic [salc_pkg::LPTR_W-1:0] wr_ptr_q;
	logic [salc_pkg::LPTR_W-1:0] rd_ptr_q;
	logic [salc_pkg::LCNT_W-1:0] cnt_q;

	function automatic logic [salc_pkg::LPTR_W-1:0] nxt(input logic [salc_pkg::LPTR_W-1:0] p);
		return (p == salc_pkg::LPTR_W'(salc_pkg::LINK_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign stat.full = (cnt_q == salc_pkg::LCNT_W'(salc_pkg::LINK_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_req = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= wr_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/salc_front.sv =====
// Request front end: takes accesses and splits the address into set index and tag.
module salc_front (
	input  logic                          push,
	output logic                          full,
	input  logic [salc_pkg::KIND_W-1:0]   kind,
	input  logic [salc_pkg::ADDR_WIDTH-1:0] address,
	input  salc_pkg::cfg_t                cfg,
	input  salc_pkg::q_stat_t             link_stat,
	output logic                          link_push,
	output salc_pkg::req_t                link_req
);

	logic [salc_pkg::SETB_W-1:0]     s_eff;
	logic [salc_pkg::SET_W-1:0]      shifted;
	logic [salc_pkg::SET_W-1:0]      mask_w;
	logic [salc_pkg::SHAMT_W-1:0]    tag_sh;

	always_comb begin
		if (int'(cfg.set_bits) > salc_pkg::MAX_SET_BITS) begin
			s_eff = salc_pkg::SETB_W'(salc_pkg::MAX_SET_BITS);
		end else begin
			s_eff = cfg.set_bits;
		end
		shifted = salc_pkg::SET_W'(address >> cfg.block_bits);
		mask_w = ~({salc_pkg::SET_W{1'b1}} << s_eff);
		tag_sh = salc_pkg::SHAMT_W'(s_eff) + salc_pkg::SHAMT_W'(cfg.block_bits);
		link_req.kind = kind;
		link_req.set_idx = shifted & mask_w;
		link_req.tag = salc_pkg::TAG_W'(address >> tag_sh);
	end

	assign full = link_stat.full;
	assign link_push = push && !link_stat.full;

endmodule

// ===== rtl/salc_back.sv =====
// Cache back end: set memory, hit and replacement logic, totals and result queue.
`include "set_assoc_lru_cache_sim_core_assert.svh"
module salc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  salc_pkg::cfg_t                  cfg,
	input  salc_pkg::q_stat_t               link_stat,
	input  salc_pkg::req_t                  link_req,
	output logic                            link_pop,
	output logic                            empty,
	input  logic                            pop,
	output logic [salc_pkg::HITS_W-1:0]     hits_now,
	output logic                            missed,
	output logic                            evicted,
	output logic [salc_pkg::CNT_W-1:0]      total_hits,
	output logic [salc_pkg::CNT_W-1:0]      total_misses,
	output logic [salc_pkg::CNT_W-1:0]      total_evictions
);

	typedef enum logic [1:0] {
		ST_FETCH  = 2'b01,
		ST_UPDATE = 2'b10
	} state_t;

	state_t state_q;

	salc_pkg::row_t row_mem [salc_pkg::NUM_SETS];
	logic [salc_pkg::NUM_SETS-1:0] row_seen_q;

	salc_pkg::req_t req_s1;
	salc_pkg::row_t row_rd_s1;
	logic           seen_s1;

	logic [salc_pkg::CNT_W-1:0] hit_total_q;
	logic [salc_pkg::CNT_W-1:0] miss_total_q;
	logic [salc_pkg::CNT_W-1:0] evict_total_q;

	salc_pkg::rsp_t out_buf_q [salc_pkg::OUT_DEPTH];
	logic [salc_pkg::OPTR_W-1:0] out_wr_q;
	logic [salc_pkg::OPTR_W-1:0] out_rd_q;
	logic [salc_pkg::OCNT_W-1:0] out_cnt_q;

	logic [salc_pkg::NW_W-1:0]   n_eff;
	logic [salc_pkg::MAX_WAYS-1:0] in_use;
	salc_pkg::row_t row_cur;
	salc_pkg::row_t row_new;
	logic hit_any;
	logic inv_any;
	logic age_all;
	logic [salc_pkg::WAY_W-1:0]  hit_way;
	logic [salc_pkg::WAY_W-1:0]  inv_way;
	logic [salc_pkg::WAY_W-1:0]  victim;
	logic [salc_pkg::WAY_W-1:0]  target;
	logic [salc_pkg::RANK_W-1:0] old_rank;
	logic                        do_access;
	logic                        wr_en;
	logic                        out_push;
	logic                        out_pop;
	salc_pkg::rsp_t              rsp;

	function automatic logic [salc_pkg::OPTR_W-1:0] nxt(input logic [salc_pkg::OPTR_W-1:0] p);
		return (p == salc_pkg::OPTR_W'(salc_pkg::OUT_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign link_pop = (state_q == ST_FETCH) && !link_stat.empty &&
		(out_cnt_q != salc_pkg::OCNT_W'(salc_pkg::OUT_DEPTH));
	assign do_access = (req_s1.kind != salc_pkg::KIND_NOP);
	assign wr_en = (state_q == ST_UPDATE) && do_access;
	assign out_push = (state_q == ST_UPDATE);
	assign out_pop = pop && !empty;

	always_comb begin
		if (cfg.ways == '0) begin
			n_eff = salc_pkg::NW_W'(1);
		end else if (int'(cfg.ways) > salc_pkg::MAX_WAYS) begin
			n_eff = salc_pkg::NW_W'(salc_pkg::MAX_WAYS);
		end else begin
			n_eff = salc_pkg::NW_W'(cfg.ways);
		end
		for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
			in_use[i] = salc_pkg::NW_W'(i) < n_eff;
		end
	end

	always_comb begin
		row_cur = seen_s1 ? row_rd_s1 : '0;
		hit_any = 1'b0;
		inv_any = 1'b0;
		hit_way = '0;
		inv_way = '0;
		for (int i = salc_pkg::MAX_WAYS - 1; i >= 0; i--) begin
			if (in_use[i] && row_cur.valid[i] && (row_cur.tag[i] == req_s1.tag)) begin
				hit_any = 1'b1;
				hit_way = salc_pkg::WAY_W'(i);
			end
			if (in_use[i] && !row_cur.valid[i]) begin
				inv_any = 1'b1;
				inv_way = salc_pkg::WAY_W'(i);
			end
		end
		victim = '0;
		for (int i = 1; i < salc_pkg::MAX_WAYS; i++) begin
			if (in_use[i] && (row_cur.rank[i] > row_cur.rank[victim])) begin
				victim = salc_pkg::WAY_W'(i);
			end
		end
		if (hit_any) begin
			target = hit_way;
			age_all = 1'b0;
		end else if (inv_any) begin
			target = inv_way;
			age_all = 1'b1;
		end else begin
			target = victim;
			age_all = 1'b0;
		end
		old_rank = row_cur.rank[target];
		row_new = row_cur;
		for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
			if (in_use[i] && (salc_pkg::WAY_W'(i) != target) && row_cur.valid[i] &&
				(age_all || (row_cur.rank[i] < old_rank)) &&
				(row_cur.rank[i] < salc_pkg::RANK_W'(salc_pkg::MAX_WAYS - 1))) begin
				row_new.rank[i] = row_cur.rank[i] + 1'b1;
			end
		end
		row_new.valid[target] = 1'b1;
		row_new.tag[target] = req_s1.tag;
		row_new.rank[target] = '0;
	end

	always_comb begin
		if (do_access) begin
			rsp.hits_now = salc_pkg::HITS_W'(hit_any) +
				salc_pkg::HITS_W'(req_s1.kind == salc_pkg::KIND_MODIFY);
			rsp.missed = !hit_any;
			rsp.evicted = !hit_any && !inv_any;
		end else begin
			rsp.hits_now = '0;
			rsp.missed = 1'b0;
			rsp.evicted = 1'b0;
		end
		rsp.total_hits = salc_pkg::sat_add(hit_total_q, rsp.hits_now);
		rsp.total_misses = salc_pkg::sat_add(miss_total_q, salc_pkg::HITS_W'(rsp.missed));
		rsp.total_evictions = salc_pkg::sat_add(evict_total_q,
			salc_pkg::HITS_W'(rsp.evicted));
	end

	always_ff @(posedge clk) begin
		if (link_pop) begin
			row_rd_s1 <= row_mem[link_req.set_idx];
			req_s1 <= link_req;
		end
		if (wr_en) begin
			row_mem[req_s1.set_idx] <= row_new;
		end
		if (out_push) begin
			out_buf_q[out_wr_q] <= rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FETCH;
			row_seen_q <= '0;
			seen_s1 <= 1'b0;
			hit_total_q <= '0;
			miss_total_q <= '0;
			evict_total_q <= '0;
			out_wr_q <= '0;
			out_rd_q <= '0;
			out_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_FETCH: begin
					if (link_pop) begin
						seen_s1 <= row_seen_q[link_req.set_idx];
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_FETCH;
				end
				default: begin
					state_q <= ST_FETCH;
				end
			endcase
			if (wr_en) begin
				row_seen_q[req_s1.set_idx] <= 1'b1;
			end
			if (out_push) begin
				hit_total_q <= rsp.total_hits;
				miss_total_q <= rsp.total_misses;
				evict_total_q <= rsp.total_evictions;
				out_wr_q <= nxt(out_wr_q);
			end
			if (out_pop) begin
				out_rd_q <= nxt(out_rd_q);
			end
			if (out_push && !out_pop) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (out_pop && !out_push) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	assign empty = (out_cnt_q == '0);
	assign hits_now = out_buf_q[out_rd_q].hits_now;
	assign missed = out_buf_q[out_rd_q].missed;
	assign evicted = out_buf_q[out_rd_q].evicted;
	assign total_hits = out_buf_q[out_rd_q].total_hits;
	assign total_misses = out_buf_q[out_rd_q].total_misses;
	assign total_evictions = out_buf_q[out_rd_q].total_evictions;

	`SALC_ASSERT_NEXT(a_fetch_then_update, link_pop, state_q == ST_UPDATE)
	`SALC_ASSERT_IMP(a_out_bound, 1'b1, out_cnt_q <= salc_pkg::OCNT_W'(salc_pkg::OUT_DEPTH))
	`SALC_ASSERT_NEXT(a_hits_monotonic, 1'b1, hit_total_q >= $past(hit_total_q))
	`SALC_ASSERT_NEXT(a_hit_keeps_misses, wr_en && hit_any, miss_total_q == $past(miss_total_q))
	`SALC_ASSERT_IMP(a_evict_is_miss, out_push && rsp.evicted, rsp.missed)

endmodule

// ===== rtl/set_assoc_lru_cache_sim_core.sv =====
// Top level of the set-associative LRU cache model: configuration registers and wiring.
//
//   channel   handshake          payload
//   request   push / full        kind, address
//   result    empty / pop        hits_now, missed, evicted, total_hits/misses/evictions
//   config    wr_en              wr_index, wr_data
//
// Each request passes the back-end states in order: ST_FETCH reads the set, then ST_UPDATE compares and writes back.
// The single-port set memory sets that order; all ways are compared in the same cycle.
// Reset clears totals, per-set empty flags, set and block bits, and sets ways to one.
// A two-entry queue decouples the front end; a full result queue stalls the back end.
module set_assoc_lru_cache_sim_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [salc_pkg::KIND_W-1:0]       kind,
	input  logic [salc_pkg::ADDR_WIDTH-1:0]   address,
	output logic                              empty,
	input  logic                              pop,
	output logic [salc_pkg::HITS_W-1:0]       hits_now,
	output logic                              missed,
	output logic                              evicted,
	output logic [salc_pkg::CNT_W-1:0]        total_hits,
	output logic [salc_pkg::CNT_W-1:0]        total_misses,
	output logic [salc_pkg::CNT_W-1:0]        total_evictions,
	input  logic                              wr_en,
	input  logic [salc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]   wr_data
);

	salc_pkg::cfg_t    cfg_q;
	salc_pkg::q_stat_t link_stat;
	salc_pkg::req_t    link_wr_req;
	salc_pkg::req_t    link_rd_req;
	logic              link_push;
	logic              link_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits <= '0;
			cfg_q.block_bits <= '0;
			cfg_q.ways <= salc_pkg::WAYS_W'(1);
		end else if (wr_en) begin
			case (wr_index)
				salc_pkg::REG_SET_BITS: begin
					cfg_q.set_bits <= wr_data[salc_pkg::SETB_W-1:0];
				end
				salc_pkg::REG_BLOCK_BITS: begin
					cfg_q.block_bits <= wr_data[salc_pkg::BLKB_W-1:0];
				end
				salc_pkg::REG_WAYS: begin
					cfg_q.ways <= wr_data[salc_pkg::WAYS_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	salc_front u_front (
		.push      (push),
		.full      (full),
		.kind      (kind),
		.address   (address),
		.cfg       (cfg_q),
		.link_stat (link_stat),
		.link_push (link_push),
		.link_req  (link_wr_req)
	);

	salc_link_q u_link_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (link_push),
		.wr_req (link_wr_req),
		.pop    (link_pop),
		.rd_req (link_rd_req),
		.stat   (link_stat)
	);

	salc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.link_stat       (link_stat),
		.link_req        (link_rd_req),
		.link_pop        (link_pop),
		.empty           (empty),
		.pop             (pop),
		.hits_now        (hits_now),
		.missed          (missed),
		.evicted         (evicted),
		.total_hits      (total_hits),
		.total_misses    (total_misses),
		.total_evictions (total_evictions)
	);

endmodule
